/* src/circuit_schedule_sequencer_unit_macros.svh */
// Assertion macros for the schedule sequencer.
`ifndef CIRCUIT_SCHEDULE_SEQUENCER_UNIT_MACROS_SVH
`define CIRCUIT_SCHEDULE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/css_pkg.sv */
`default_nettype none

package css_pkg;

  localparam int CSS_MAX_HOSTS   = 16;
  localparam int CSS_MAX_SLOTS   = 16;
  localparam int CSS_LOOKAHEAD   = 2;
  localparam int CSS_MAX_RESULTS = 64;

  localparam logic [4:0]  RST_HOST_COUNT     = 5'd4;
  localparam logic [4:0]  RST_SLOT_COUNT     = 5'd1;
  localparam logic [15:0] RST_BIG_CAPACITY   = 16'd100;
  localparam logic [15:0] RST_SMALL_CAPACITY = 16'd10;

  localparam logic [1:0] FUNC_LOAD_DUR = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SRC = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  localparam logic [2:0] REG_HOST_COUNT     = 3'd0;
  localparam logic [2:0] REG_SLOT_COUNT     = 3'd1;
  localparam logic [2:0] REG_BIG_CAPACITY   = 3'd2;
  localparam logic [2:0] REG_SMALL_CAPACITY = 3'd3;
  localparam logic [2:0] REG_RESIZE_ENABLE  = 3'd4;
  localparam logic [2:0] REG_RUN_ENABLE     = 3'd5;

  localparam logic ACT_SWITCH   = 1'b0;
  localparam logic ACT_CAPACITY = 1'b1;

  localparam logic signed [4:0] NO_CIRCUIT = -5'sd1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRAP,
    OP_SCAN_BIG,
    OP_LOOK,
    OP_SWPREP,
    OP_SCAN_SW,
    OP_MARK,
    OP_DREAD,
    OP_DCHK,
    OP_SCAN_SMALL,
    OP_ADV,
    OP_FLUSH
  } css_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOTICK,
    C_STARTED,
    C_NORESIZE,
    C_SCANMORE,
    C_LOOKMORE,
    C_NOTEXPIRED
  } css_cond_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_WRAP     = 4'd1,
    S_BIGCHK   = 4'd2,
    S_BIG      = 4'd3,
    S_BIGNEXT  = 4'd4,
    S_SWPREP   = 4'd5,
    S_SW       = 4'd6,
    S_STARTED  = 4'd7,
    S_DREAD    = 4'd8,
    S_DCHK     = 4'd9,
    S_SMALLCHK = 4'd10,
    S_SMALL    = 4'd11,
    S_ADV      = 4'd12,
    S_FLUSH    = 4'd13
  } css_step_t;

  typedef struct packed {
    css_op_t   op;
    css_cond_t cond;
    css_step_t target;
  } css_ctrl_t;

  typedef struct packed {
    logic tick_go;
    logic started;
    logic resize;
    logic scan_more;
    logic look_more;
    logic expired;
  } css_flags_t;

  typedef struct packed {
    logic [4:0]  host_count;
    logic [4:0]  slot_count;
    logic [15:0] big_capacity;
    logic [15:0] small_capacity;
    logic        resize_enable;
    logic        run_enable;
  } css_cfg_t;

  // Control store: op, jump condition, jump target. Fall through to step + 1.
  function automatic css_ctrl_t css_microcode(input css_step_t s);
    css_ctrl_t w;
    case (s)
      S_IDLE:     w = '{OP_NOP,        C_NOTICK,     S_IDLE};
      S_WRAP:     w = '{OP_WRAP,       C_STARTED,    S_DREAD};
      S_BIGCHK:   w = '{OP_NOP,        C_NORESIZE,   S_SWPREP};
      S_BIG:      w = '{OP_SCAN_BIG,   C_SCANMORE,   S_BIG};
      S_BIGNEXT:  w = '{OP_LOOK,       C_LOOKMORE,   S_BIG};
      S_SWPREP:   w = '{OP_SWPREP,     C_NEVER,      S_IDLE};
      S_SW:       w = '{OP_SCAN_SW,    C_SCANMORE,   S_SW};
      S_STARTED:  w = '{OP_MARK,       C_ALWAYS,     S_FLUSH};
      S_DREAD:    w = '{OP_DREAD,      C_NEVER,      S_IDLE};
      S_DCHK:     w = '{OP_DCHK,       C_NOTEXPIRED, S_FLUSH};
      S_SMALLCHK: w = '{OP_NOP,        C_NORESIZE,   S_ADV};
      S_SMALL:    w = '{OP_SCAN_SMALL, C_SCANMORE,   S_SMALL};
      S_ADV:      w = '{OP_ADV,        C_NEVER,      S_IDLE};
      S_FLUSH:    w = '{OP_FLUSH,      C_ALWAYS,     S_IDLE};
      default:    w = '{OP_NOP,        C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/css_sequencer.sv */
`default_nettype none

module css_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  css_pkg::css_flags_t flags,
  output css_pkg::css_ctrl_t  ctrl,
  output logic                busy
);
  import css_pkg::*;

  css_step_t step;
  logic      jump;

  assign ctrl = css_microcode(step);
  assign busy = (step != S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NOTICK:     jump = !flags.tick_go;
      C_STARTED:    jump = flags.started;
      C_NORESIZE:   jump = !flags.resize;
      C_SCANMORE:   jump = flags.scan_more;
      C_LOOKMORE:   jump = flags.look_more;
      C_NOTEXPIRED: jump = !flags.expired;
      default:      jump = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else if (jump) begin
      step <= ctrl.target;
    end else begin
      step <= css_step_t'(step + 4'd1);
    end
  end

endmodule

`default_nettype wire

/* src/css_datapath.sv */
`default_nettype none

module css_datapath #(
  parameter int MAX_HOSTS = css_pkg::CSS_MAX_HOSTS,
  parameter int MAX_SLOTS = css_pkg::CSS_MAX_SLOTS,
  parameter int LOOKAHEAD = css_pkg::CSS_LOOKAHEAD
) (
  input  logic                clk,
  input  logic                rst,
  input  css_pkg::css_ctrl_t  ctrl,
  input  css_pkg::css_cfg_t   cfg,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          func,
  input  logic [3:0]          slot_index,
  input  logic [3:0]          dest_index,
  input  logic [19:0]         duration_us,
  input  logic signed [4:0]   source_port,
  output css_pkg::css_flags_t flags,
  output logic                result_valid,
  output logic                action,
  output logic [3:0]          out_dest,
  output logic signed [4:0]   out_source,
  output logic [15:0]         capacity,
  output logic                last
);
  import css_pkg::*;

  localparam int HW    = $clog2(MAX_HOSTS);
  localparam int HCW   = $clog2(MAX_HOSTS + 1);
  localparam int SLW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW   = $clog2(MAX_SLOTS + 1);
  localparam int KW    = (LOOKAHEAD > 0) ? $clog2(LOOKAHEAD + 1) : 1;
  localparam int DEPTH = MAX_SLOTS * MAX_HOSTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(CSS_MAX_RESULTS + 1);

  typedef enum logic [1:0] {KIND_SWITCH, KIND_BIG, KIND_SMALL} kind_t;

  logic [19:0] dur_mem [MAX_SLOTS];
  logic [4:0]  src_mem [DEPTH];

  logic [HCW-1:0]  hosts_eff;
  logic [SCW-1:0]  slots_eff;
  logic [SLW-1:0]  cur, cur_w, scan_slot;
  logic [HW-1:0]   d;
  logic [KW-1:0]   k;
  logic [19:0]     elapsed, elapsed_inc, dur_q, dur1;
  logic            started;
  logic [AW-1:0]   src_addr, load_addr;
  logic [4:0]      src_q;
  logic            tvalid;
  kind_t           tkind;
  logic [HW-1:0]   tdest;
  logic [CNTW-1:0] cnt;
  logic            accept;

  logic             circ_ok, cand_ok, take;
  logic             cand_action;
  logic signed [4:0] cand_source;
  logic [15:0]      cand_cap;

  logic             pend_valid;
  logic             pend_action;
  logic [HW-1:0]    pend_dest;
  logic signed [4:0] pend_source;
  logic [15:0]      pend_cap;
  logic             emit_mid, emit_last;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s,
                                              input logic [SCW-1:0] n);
    logic [SLW-1:0] r;
    if (32'(s) + 1 >= 32'(n)) r = '0;
    else r = s + SLW'(1);
    return r;
  endfunction

  always_comb begin
    if (cfg.host_count == 5'd0) hosts_eff = HCW'(1);
    else if (32'(cfg.host_count) > MAX_HOSTS) hosts_eff = HCW'(MAX_HOSTS);
    else hosts_eff = HCW'(cfg.host_count);
    if (cfg.slot_count == 5'd0) slots_eff = SCW'(1);
    else if (32'(cfg.slot_count) > MAX_SLOTS) slots_eff = SCW'(MAX_SLOTS);
    else slots_eff = SCW'(cfg.slot_count);
  end

  assign accept      = start && !busy;
  assign cur_w       = (32'(cur) >= 32'(slots_eff)) ? '0 : cur;
  assign dur1        = (dur_q == 20'd0) ? 20'd1 : dur_q;
  assign elapsed_inc = (elapsed != 20'hFFFFF) ? elapsed + 20'd1 : elapsed;
  assign src_addr    = AW'(32'(scan_slot) * MAX_HOSTS + 32'(d));
  assign load_addr   = AW'(32'(slot_index) * MAX_HOSTS + 32'(dest_index));

  assign flags.tick_go   = start && (func == FUNC_TICK) && cfg.run_enable;
  assign flags.started   = started;
  assign flags.resize    = cfg.resize_enable;
  assign flags.scan_more = (32'(d) + 1 < 32'(hosts_eff));
  assign flags.look_more = (32'(k) < LOOKAHEAD);
  assign flags.expired   = (elapsed_inc >= dur1);

  // Tables: loads while idle, registered reads.
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD_DUR && 32'(slot_index) < MAX_SLOTS) begin
      dur_mem[SLW'(slot_index)] <= duration_us;
    end
    if (accept && func == FUNC_LOAD_SRC && 32'(slot_index) < MAX_SLOTS &&
        32'(dest_index) < MAX_HOSTS) begin
      src_mem[load_addr] <= source_port;
    end
    if (ctrl.op == OP_DREAD) begin
      dur_q <= dur_mem[cur];
    end
    src_q <= src_mem[src_addr];
    tdest <= d;
  end

  // Schedule state and scan counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      scan_slot <= '0;
      d       <= '0;
      k       <= '0;
      elapsed <= '0;
      started <= 1'b0;
      tvalid  <= 1'b0;
      tkind   <= KIND_SWITCH;
    end else begin
      tvalid <= 1'b0;
      case (ctrl.op)
        OP_WRAP: begin
          cur       <= cur_w;
          scan_slot <= cur_w;
          d         <= '0;
          k         <= '0;
        end
        OP_SCAN_BIG, OP_SCAN_SW, OP_SCAN_SMALL: begin
          d      <= flags.scan_more ? d + HW'(1) : '0;
          tvalid <= 1'b1;
          if (ctrl.op == OP_SCAN_BIG) tkind <= KIND_BIG;
          else if (ctrl.op == OP_SCAN_SMALL) tkind <= KIND_SMALL;
          else tkind <= KIND_SWITCH;
        end
        OP_LOOK: begin
          k         <= k + KW'(1);
          scan_slot <= slot_inc(scan_slot, slots_eff);
        end
        OP_SWPREP: begin
          scan_slot <= cur;
          d         <= '0;
        end
        OP_MARK: begin
          elapsed <= '0;
          started <= 1'b1;
        end
        OP_DCHK: begin
          elapsed <= elapsed_inc;
        end
        OP_ADV: begin
          cur     <= slot_inc(cur, slots_eff);
          elapsed <= '0;
          started <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Turn one table entry into a result candidate.
  assign circ_ok = !src_q[4] && (32'(src_q) < 32'(hosts_eff));

  always_comb begin
    cand_ok     = 1'b0;
    cand_action = ACT_SWITCH;
    cand_source = NO_CIRCUIT;
    cand_cap    = 16'd0;
    case (tkind)
      KIND_SWITCH: begin
        cand_ok     = tvalid;
        cand_source = circ_ok ? src_q : NO_CIRCUIT;
      end
      KIND_BIG: begin
        cand_ok     = tvalid && circ_ok;
        cand_action = ACT_CAPACITY;
        cand_source = src_q;
        cand_cap    = cfg.big_capacity;
      end
      KIND_SMALL: begin
        cand_ok     = tvalid && circ_ok;
        cand_action = ACT_CAPACITY;
        cand_source = src_q;
        cand_cap    = cfg.small_capacity;
      end
      default: begin
      end
    endcase
  end

  assign take      = cand_ok && (32'(cnt) < CSS_MAX_RESULTS);
  assign emit_mid  = take && pend_valid;
  assign emit_last = !take && (ctrl.op == OP_FLUSH) && pend_valid;

  // One result held back so the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_mid || emit_last;
      if (ctrl.op == OP_WRAP) begin
        cnt <= '0;
      end else if (take) begin
        cnt <= cnt + CNTW'(1);
      end
      if (take) begin
        pend_valid <= 1'b1;
      end else if (emit_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_mid || emit_last) begin
      action     <= pend_action;
      out_dest   <= 4'(pend_dest);
      out_source <= pend_source;
      capacity   <= pend_cap;
      last       <= emit_last;
    end
    if (take) begin
      pend_action <= cand_action;
      pend_dest   <= tdest;
      pend_source <= cand_source;
      pend_cap    <= cand_cap;
    end
  end

endmodule

`default_nettype wire

/* src/circuit_schedule_sequencer_unit.sv */
// Busy stays high while a running tick walks the step program: a slot start scans big capacity
// writes for the lookahead window (with resizing) and then switch settings, a slot end scans small
// capacity writes (with resizing), any other running tick only counts; loads and stopped ticks leave it low.
// Results come out at most one per cycle, each held until the next is found so the final one can
// carry last; the last lands in the first cycle with busy low. One item at a time, no stalls.
// Reset (rst, synchronous): slot 0, not started, registers at defaults; tables are not cleared.
`default_nettype none
`include "circuit_schedule_sequencer_unit_macros.svh"

module circuit_schedule_sequencer_unit #(
  parameter int MAX_HOSTS = css_pkg::CSS_MAX_HOSTS,
  parameter int MAX_SLOTS = css_pkg::CSS_MAX_SLOTS,
  parameter int LOOKAHEAD = css_pkg::CSS_LOOKAHEAD
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [3:0]        slot_index,
  input  logic [3:0]        dest_index,
  input  logic [19:0]       duration_us,
  input  logic signed [4:0] source_port,
  input  logic              write_enable,
  input  logic [2:0]        write_index,
  input  logic [15:0]       write_data,
  output logic              result_valid,
  output logic              action,
  output logic [3:0]        out_dest,
  output logic signed [4:0] out_source,
  output logic [15:0]       capacity,
  output logic              last
);
  import css_pkg::*;

  css_cfg_t   cfg;
  css_ctrl_t  ctrl;
  css_flags_t flags;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.host_count     <= RST_HOST_COUNT;
      cfg.slot_count     <= RST_SLOT_COUNT;
      cfg.big_capacity   <= RST_BIG_CAPACITY;
      cfg.small_capacity <= RST_SMALL_CAPACITY;
      cfg.resize_enable  <= 1'b0;
      cfg.run_enable     <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        REG_HOST_COUNT:     cfg.host_count     <= write_data[4:0];
        REG_SLOT_COUNT:     cfg.slot_count     <= write_data[4:0];
        REG_BIG_CAPACITY:   cfg.big_capacity   <= write_data;
        REG_SMALL_CAPACITY: cfg.small_capacity <= write_data;
        REG_RESIZE_ENABLE:  cfg.resize_enable  <= write_data[0];
        REG_RUN_ENABLE:     cfg.run_enable     <= write_data[0];
        default: begin
        end
      endcase
    end
  end

  // Step counter and control store: walks the tick program, idles otherwise.
  css_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Tables, schedule state, scan pipeline and result staging.
  css_datapath #(
    .MAX_HOSTS (MAX_HOSTS),
    .MAX_SLOTS (MAX_SLOTS),
    .LOOKAHEAD (LOOKAHEAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .slot_index   (slot_index),
    .dest_index   (dest_index),
    .duration_us  (duration_us),
    .source_port  (source_port),
    .flags        (flags),
    .result_valid (result_valid),
    .action       (action),
    .out_dest     (out_dest),
    .out_source   (out_source),
    .capacity     (capacity),
    .last         (last)
  );

  // The final result of an item is never directly followed by another one.
  `CSSU_ASSERT_NEXT(a_last_gap, result_valid && last, !result_valid, "result after last")
  // Switch settings carry no capacity.
  `CSSU_ASSERT_NOW(a_switch_cap, result_valid && action == ACT_SWITCH, capacity == 16'd0,
    "switch setting with capacity")
  // Capacity writes always name a real source port.
  `CSSU_ASSERT_NOW(a_cap_src, result_valid && action == ACT_CAPACITY, !out_source[4],
    "capacity write without circuit")
  // Loads and unknown functions finish in the accepting cycle.
  `CSSU_ASSERT_NEXT(a_load_quick, start && !busy && func != FUNC_TICK, !busy,
    "non-tick item left block busy")

endmodule

`default_nettype wire

/* sim/circuit_schedule_sequencer_unit_tb.sv */
`timescale 1ns / 1ps

module circuit_schedule_sequencer_unit_tb;
  import css_pkg::*;

  // Codes the package leaves unnamed: the spare func value and the two spare
  // register indexes. The block must ignore all three.
  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // The settle wait outlasts the busy time of a slot start with 16 hosts, so the
  // registers are touched only after the block has gone idle.
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 500;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    logic              act;
    logic [3:0]        dest;
    logic signed [4:0] src;
    logic [15:0]       cap;
    logic              last;
  } switch_action_t;

  // Tracks the schedule next to the block and holds the actions it owes.
  class sequencer_scoreboard;
    logic [19:0]       slot_length [CSS_MAX_SLOTS];
    logic [4:0]        slot_source [CSS_MAX_SLOTS * CSS_MAX_HOSTS];
    int unsigned       now_slot;
    logic [19:0]       ticks_in_slot;
    bit                slot_live;
    css_cfg_t          cfg;
    switch_action_t    pending_actions [$];
    switch_action_t    tick_actions [$];
    int unsigned       mismatches;
    int unsigned       actions_seen;
    int unsigned       ticks_run;

    function new();
      foreach (slot_length[i]) slot_length[i] = '0;
      foreach (slot_source[i]) slot_source[i] = '0;
      now_slot      = 0;
      ticks_in_slot = '0;
      slot_live     = 1'b0;
      cfg = '{RST_HOST_COUNT, RST_SLOT_COUNT, RST_BIG_CAPACITY, RST_SMALL_CAPACITY,
              1'b0, 1'b0};
      mismatches   = 0;
      actions_seen = 0;
      ticks_run    = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
        REG_HOST_COUNT:     cfg.host_count     = data[4:0];
        REG_SLOT_COUNT:     cfg.slot_count     = data[4:0];
        REG_BIG_CAPACITY:   cfg.big_capacity   = data;
        REG_SMALL_CAPACITY: cfg.small_capacity = data;
        REG_RESIZE_ENABLE:  cfg.resize_enable  = data[0];
        REG_RUN_ENABLE:     cfg.run_enable     = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned hosts_in_use();
      int unsigned h;
      h = cfg.host_count;
      if (h < 1) h = 1;
      if (h > CSS_MAX_HOSTS) h = CSS_MAX_HOSTS;
      return h;
    endfunction

    function int unsigned slots_in_use();
      int unsigned s;
      s = cfg.slot_count;
      if (s < 1) s = 1;
      if (s > CSS_MAX_SLOTS) s = CSS_MAX_SLOTS;
      return s;
    endfunction

    // Anything outside 0..hosts-1 counts as no circuit.
    function logic signed [4:0] source_of(input int unsigned slot, input int unsigned dest,
                                          input int unsigned hosts);
      logic signed [4:0] raw;
      int                sv;
      raw = slot_source[slot * CSS_MAX_HOSTS + dest];
      sv  = raw;
      if (sv < 0 || sv >= int'(hosts)) return NO_CIRCUIT;
      return raw;
    endfunction

    function void add_action(input logic act, input int unsigned dest,
                             input logic signed [4:0] src, input logic [15:0] cap);
      switch_action_t a;
      if (tick_actions.size() >= CSS_MAX_RESULTS) return;
      a.act  = act;
      a.dest = 4'(dest);
      a.src  = src;
      a.cap  = cap;
      a.last = 1'b0;
      tick_actions = {tick_actions, a};
    endfunction

    function void add_capacity_writes(input int unsigned slot, input int unsigned hosts,
                                      input logic [15:0] cap);
      logic signed [4:0] s;
      for (int unsigned d = 0; d < hosts; d++) begin
        s = source_of(slot, d, hosts);
        if (s != NO_CIRCUIT) add_action(ACT_CAPACITY, d, s, cap);
      end
    endfunction

    function void advance_schedule();
      int unsigned hosts;
      int unsigned slots;
      int unsigned length;
      hosts = hosts_in_use();
      slots = slots_in_use();
      if (now_slot >= slots) now_slot = 0;
      if (!slot_live) begin
        if (cfg.resize_enable)
          for (int unsigned k = 0; k <= CSS_LOOKAHEAD; k++)
            add_capacity_writes((now_slot + k) % slots, hosts, cfg.big_capacity);
        for (int unsigned d = 0; d < hosts; d++)
          add_action(ACT_SWITCH, d, source_of(now_slot, d, hosts), 16'd0);
        ticks_in_slot = '0;
        slot_live     = 1'b1;
      end else begin
        length = slot_length[now_slot];
        if (length < 1) length = 1;
        if (ticks_in_slot != 20'hFFFFF) ticks_in_slot++;
        if (ticks_in_slot >= length) begin
          if (cfg.resize_enable) add_capacity_writes(now_slot, hosts, cfg.small_capacity);
          now_slot      = (now_slot + 1) % slots;
          ticks_in_slot = '0;
          slot_live     = 1'b0;
        end
      end
    endfunction

    function void note_item(input logic [1:0] fn, input logic [3:0] slot,
                            input logic [3:0] dest, input logic [19:0] dur,
                            input logic signed [4:0] src);
      tick_actions.delete();
      case (fn)
        FUNC_LOAD_DUR: slot_length[slot] = dur;
        FUNC_LOAD_SRC: slot_source[{slot, dest}] = src;
        FUNC_TICK: begin
          ticks_run++;
          if (cfg.run_enable) advance_schedule();
        end
        default: ;
      endcase
      if (tick_actions.size() > 0) tick_actions[tick_actions.size() - 1].last = 1'b1;
      pending_actions = {pending_actions, tick_actions};
    endfunction

    function void check_action(input logic act, input logic [3:0] dest,
                               input logic signed [4:0] src, input logic [15:0] cap,
                               input logic last);
      switch_action_t want;
      actions_seen++;
      if (pending_actions.size() == 0) begin
        $error("unexpected action %0d dest %0d source %0d capacity %0d last %0d",
               act, dest, src, cap, last);
        mismatches++;
        return;
      end
      want = pending_actions.pop_front();
      if (act !== want.act) begin
        $error("action: expected %0d, got %0d", want.act, act);
        mismatches++;
      end
      if (dest !== want.dest) begin
        $error("out_dest: expected %0d, got %0d", want.dest, dest);
        mismatches++;
      end
      if (src !== want.src) begin
        $error("out_source: expected %0d, got %0d", want.src, src);
        mismatches++;
      end
      if (cap !== want.cap) begin
        $error("capacity: expected %0d, got %0d", want.cap, cap);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        func = FUNC_LOAD_DUR;
  logic [3:0]        slot_index = '0;
  logic [3:0]        dest_index = '0;
  logic [19:0]       duration_us = '0;
  logic signed [4:0] source_port = '0;
  logic              write_enable = 1'b0;
  logic [2:0]        write_index = REG_HOST_COUNT;
  logic [15:0]       write_data = '0;
  logic              result_valid;
  logic              action;
  logic [3:0]        out_dest;
  logic signed [4:0] out_source;
  logic [15:0]       capacity;
  logic              last;

  sequencer_scoreboard sb;
  bit                  no_gaps = 1'b0;
  int unsigned         items_sent = 0;
  int unsigned         settings_run = 0;
  int unsigned         quiet_cycles = 0;

  circuit_schedule_sequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .slot_index   (slot_index),
    .dest_index   (dest_index),
    .duration_us  (duration_us),
    .source_port  (source_port),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .result_valid (result_valid),
    .action       (action),
    .out_dest     (out_dest),
    .out_source   (out_source),
    .capacity     (capacity),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Results cannot be held off: take each one at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_action(action, out_dest, out_source, capacity, last);
  end

  // Count cycles where nothing moves on any port; a hung block ends the run here.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || write_enable) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item after a random gap and hold it until busy drops at an edge.
  // start stays high when the next item follows with no gap.
  task automatic send_item(input logic [1:0] fn, input logic [3:0] slot,
                           input logic [3:0] dest, input logic [19:0] dur,
                           input logic signed [4:0] src);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= fn;
    slot_index  <= slot;
    dest_index  <= dest;
    duration_us <= dur;
    source_port <= src;
    do @(posedge clk); while (busy);
    sb.note_item(fn, slot, dest, dur, src);
    items_sent++;
  endtask

  // Ticks carry random junk in the fields the block must not look at.
  task automatic tick();
    send_item(FUNC_TICK, 4'($urandom), 4'($urandom), 20'($urandom), 5'($urandom));
  endtask

  task automatic load_length(input logic [3:0] slot, input logic [19:0] dur);
    send_item(FUNC_LOAD_DUR, slot, 4'($urandom), dur, 5'($urandom));
  endtask

  task automatic load_source(input logic [3:0] slot, input logic [3:0] dest,
                             input logic signed [4:0] src);
    send_item(FUNC_LOAD_SRC, slot, dest, 20'($urandom), src);
  endtask

  // Lean toward live circuits for the current host count; keep some bad values.
  function automatic logic signed [4:0] pick_source();
    if ($urandom_range(0, 9) < 6) return 5'($urandom_range(0, sb.hosts_in_use() - 1));
    return 5'($urandom);
  endfunction

  // Drop start and wait until every owed action has come out, then let the
  // block finish any silent tail of the last tick.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [15:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write the whole register set. Junk goes into the bits above each field.
  task automatic set_config(input logic [4:0] hosts, input logic [4:0] slots,
                            input logic [15:0] big, input logic [15:0] small_cap,
                            input logic resize, input logic run);
    program_reg(REG_HOST_COUNT,     {11'($urandom), hosts});
    program_reg(REG_SLOT_COUNT,     {11'($urandom), slots});
    program_reg(REG_BIG_CAPACITY,   big);
    program_reg(REG_SMALL_CAPACITY, small_cap);
    program_reg(REG_RESIZE_ENABLE,  {15'($urandom), resize});
    program_reg(REG_RUN_ENABLE,     {15'($urandom), run});
    write_enable <= 1'b0;
    settings_run++;
  endtask

  // Mostly ticks so the schedule keeps turning, with table rewrites and spare
  // funcs mixed in. Sender pauses to drain once, halfway through.
  task automatic run_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == count / 2) settle();
      pick = $urandom_range(0, 99);
      if (pick < 70)
        tick();
      else if (pick < 82)
        load_length(4'($urandom), ($urandom_range(0, 19) == 0) ? 20'($urandom)
                                                               : 20'($urandom_range(0, 3)));
      else if (pick < 95)
        load_source(4'($urandom), 4'($urandom), pick_source());
      else
        send_item(FUNC_SPARE, 4'($urandom), 4'($urandom), 20'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Fill both tables while the schedule is stopped, so nothing reads an
    // entry that was never written.
    for (int s = 0; s < CSS_MAX_SLOTS; s++) load_length(4'(s), 20'($urandom_range(0, 3)));
    for (int s = 0; s < CSS_MAX_SLOTS; s++)
      for (int d = 0; d < CSS_MAX_HOSTS; d++) load_source(4'(s), 4'(d), pick_source());
    settle();

    // Directed: three hosts, three slots, capacities at their extremes.
    set_config(5'd3, 5'd3, 16'hFFFF, 16'd1, 1'b1, 1'b1);
    load_length(4'd0, 20'd0);           // zero duration still lasts one tick
    load_length(4'd1, 20'd2);
    load_length(4'd2, 20'hFFFFF);       // longest slot, cut short below
    load_source(4'd0, 4'd0, 5'sd2);     // top valid host
    load_source(4'd0, 4'd1, NO_CIRCUIT);
    load_source(4'd0, 4'd2, 5'sd3);     // one past host count: no circuit
    load_source(4'd1, 4'd0, 5'sd0);
    load_source(4'd1, 4'd1, -5'sd16);   // most negative: no circuit
    load_source(4'd1, 4'd2, 5'sd15);
    load_source(4'd2, 4'd0, 5'sd2);
    load_source(4'd2, 4'd1, 5'sd1);
    send_item(FUNC_SPARE, 4'hF, 4'hF, 20'hFFFFF, NO_CIRCUIT);
    tick();                             // slot 0 start: lookahead over 0, 1, 2
    tick();                             // slot 0 ends after one tick
    tick();                             // slot 1 start
    tick();
    tick();                             // slot 1 ends
    tick();                             // slot 2 start
    tick();
    load_length(4'd2, 20'd1);           // shorten the running slot
    tick();                             // slot 2 ends
    tick();                             // wrap back to slot 0
    settle();

    // Largest schedule: slot starts come close to the 64-action limit.
    set_config(5'd16, 5'd16, 16'hFFFF, 16'd1, 1'b1, 1'b1);
    run_random(14);
    settle();

    set_config(5'd1, 5'd1, 16'd1, 16'hFFFF, 1'b1, 1'b1);
    run_random(8);
    settle();

    // Counts below range saturate up to one.
    set_config(5'd0, 5'd0, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               1'b1, 1'b1);
    run_random(8);
    settle();

    // Counts above range saturate down; the spare indexes must change nothing.
    set_config(5'd31, 5'd20, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               1'b1, 1'b1);
    @(posedge clk);
    program_reg(REG_SPARE_LO, 16'hFFFF);
    program_reg(REG_SPARE_HI, 16'($urandom));
    write_enable <= 1'b0;
    run_random(8);
    settle();

    // Shrink the slot count under a running schedule: a current slot past the
    // new count wraps to slot 0. Resizing off leaves only switch settings.
    set_config(5'd7, 5'd5, 16'd100, 16'd10, 1'b0, 1'b1);
    run_random(10);
    settle();

    // Stopped: ticks are dropped and the schedule holds where it is.
    set_config(5'd16, 5'd16, 16'd100, 16'd10, 1'b1, 1'b0);
    run_random(6);
    settle();

    for (int p = 0; p < 2; p++) begin
      set_config(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 1'b1, 1'b1);
      run_random(6);
      settle();
    end

    // Final drain, bounded so a missing action is reported rather than hung on.
    start <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && sb.pending_actions.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_actions.size() != 0) begin
      $error("%0d actions never arrived", sb.pending_actions.size());
      sb.mismatches += sb.pending_actions.size();
    end

    $display("covered %0d items (%0d ticks) across %0d register settings",
             items_sent, sb.ticks_run, settings_run);
    $display("checked %0d switch and capacity actions, %0d mismatches",
             sb.actions_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
